// ----- design/particle_block_offset_builder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the particle block offset builder
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_BLOCK_OFFSET_BUILDER_ASSERT_SVH
`define PARTICLE_BLOCK_OFFSET_BUILDER_ASSERT_SVH

// expr must never hold
`define PBOB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

// whenever ante holds, cons holds in the same cycle
`define PBOB_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/pbob_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbob_pkg
// Shared constants and types of the particle block offset builder.
// ----------------------------------------------------------------------------
package pbob_pkg;

  localparam int BLOCK_X       = 4;
  localparam int BLOCK_Y       = 4;
  localparam int BLOCK_Z       = 4;
  localparam int MAX_BLOCKS    = 4096;
  localparam int MAX_PARTICLES = 1048576;

  localparam int POS_W  = 32;
  localparam int INV_W  = 32;
  localparam int SLOT_W = 13;
  localparam int IDX_W  = 21;
  localparam int PREV_W = 14;
  localparam int PROD_W = POS_W + INV_W + 1;
  localparam int FRAC_W = 40;
  localparam int CELL_W = PROD_W - FRAC_W;
  localparam int ZY_W   = 2 * SLOT_W;
  localparam int ZYB_W  = ZY_W + 1;
  localparam int LIN_W  = ZYB_W + SLOT_W;
  localparam int CNT_W  = 3 * SLOT_W;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_ORDER = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    REG_INV_X    = 3'd0,
    REG_INV_Y    = 3'd1,
    REG_INV_Z    = 3'd2,
    REG_BLOCKS_X = 3'd3,
    REG_BLOCKS_Y = 3'd4,
    REG_BLOCKS_Z = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [INV_W-1:0]  inv_x;
    logic [INV_W-1:0]  inv_y;
    logic [INV_W-1:0]  inv_z;
    logic [SLOT_W-1:0] blocks_x;
    logic [SLOT_W-1:0] blocks_y;
    logic [SLOT_W-1:0] blocks_z;
    logic [SLOT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic              is_end;
    logic              bad;
    logic [SLOT_W-1:0] block;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ----- design/particle_block_offset_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_block_offset_builder
// Bins sorted particle positions into blocks and emits offset table ranges.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  pos_x_i pos_y_i pos_z_i is_end_i
// out      output     out_valid_o/out_stall_i  first_slot_o last_slot_o
//                                              start_index_o error_code_o
// cfg      input      APB write, pready high  paddr pwdata (prdata read back)
//
// One item per cycle while the output is not stalled; six-stage block index
// pipeline, a four-entry queue, and a back end that feeds the output register.
// Block count is registered from the blocks registers via a registered x*y product.
// rst_ni clears pipeline valids, queue pointers and the order state, and resets config to defaults.
// A stalled output holds the back end; a full queue then stalls the input.
// ----------------------------------------------------------------------------
module particle_block_offset_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pbob_pkg::POS_W-1:0]   pos_x_i,
  input  logic [pbob_pkg::POS_W-1:0]   pos_y_i,
  input  logic [pbob_pkg::POS_W-1:0]   pos_z_i,
  input  logic                         is_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pbob_pkg::SLOT_W-1:0]  first_slot_o,
  output logic [pbob_pkg::SLOT_W-1:0]  last_slot_o,
  output logic [pbob_pkg::IDX_W-1:0]   start_index_o,
  output logic [1:0]                   error_code_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pbob_pkg::*;

  `include "particle_block_offset_builder_assert.svh"

  logic [INV_W-1:0]  inv_x_q, inv_y_q, inv_z_q;
  logic [SLOT_W-1:0] bx_q, by_q, bz_q;
  logic [ZY_W-1:0]   xy_q;
  logic [CNT_W-1:0]  xyz;
  logic [SLOT_W-1:0] count_q, count_d;
  logic              wr_en;
  reg_idx_e          idx;

  cfg_t         cfg;
  item_t        front_item, back_item;
  fifo_status_t fifo_st;
  logic         fifo_push, fifo_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q <= INV_W'(32'h0100_0000);
      inv_y_q <= INV_W'(32'h0100_0000);
      inv_z_q <= INV_W'(32'h0100_0000);
      bx_q    <= SLOT_W'(1);
      by_q    <= SLOT_W'(1);
      bz_q    <= SLOT_W'(1);
      xy_q    <= ZY_W'(1);
      count_q <= SLOT_W'(1);
    end else begin
      xy_q    <= ZY_W'(bx_q) * ZY_W'(by_q);
      count_q <= count_d;
      if (wr_en) begin
        case (idx)
          REG_INV_X:    inv_x_q <= pwdata;
          REG_INV_Y:    inv_y_q <= pwdata;
          REG_INV_Z:    inv_z_q <= pwdata;
          REG_BLOCKS_X: bx_q    <= pwdata[SLOT_W-1:0];
          REG_BLOCKS_Y: by_q    <= pwdata[SLOT_W-1:0];
          REG_BLOCKS_Z: bz_q    <= pwdata[SLOT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign xyz     = CNT_W'(xy_q) * CNT_W'(bz_q);
  assign count_d = (xyz > CNT_W'(MAX_BLOCKS)) ? SLOT_W'(MAX_BLOCKS) : xyz[SLOT_W-1:0];

  always_comb begin
    case (idx)
      REG_INV_X:    prdata = inv_x_q;
      REG_INV_Y:    prdata = inv_y_q;
      REG_INV_Z:    prdata = inv_z_q;
      REG_BLOCKS_X: prdata = {{(32-SLOT_W){1'b0}}, bx_q};
      REG_BLOCKS_Y: prdata = {{(32-SLOT_W){1'b0}}, by_q};
      REG_BLOCKS_Z: prdata = {{(32-SLOT_W){1'b0}}, bz_q};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg.inv_x    = inv_x_q;
    cfg.inv_y    = inv_y_q;
    cfg.inv_z    = inv_z_q;
    cfg.blocks_x = bx_q;
    cfg.blocks_y = by_q;
    cfg.blocks_z = bz_q;
    cfg.count    = count_q;
  end

  pbob_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .is_end_i    (is_end_i),
    .fifo_full_i (fifo_st.full),
    .push_o      (fifo_push),
    .item_o      (front_item)
  );

  pbob_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fifo_push),
    .item_i   (front_item),
    .pop_i    (fifo_pop),
    .item_o   (back_item),
    .status_o (fifo_st)
  );

  pbob_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (back_item),
    .item_valid_i  (!fifo_st.empty),
    .pop_o         (fifo_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .first_slot_o  (first_slot_o),
    .last_slot_o   (last_slot_o),
    .start_index_o (start_index_o),
    .error_code_o  (error_code_o)
  );

  `PBOB_NEVER(a_fifo_no_overflow, fifo_push && fifo_st.full, "queue push while full")
  `PBOB_IMPLY(a_err_fields_zero, out_valid_o && error_code_o != ERR_OK, first_slot_o == '0 && last_slot_o == '0 && start_index_o == '0, "error transfer with nonzero fields")
  `PBOB_IMPLY(a_range_ordered, out_valid_o && error_code_o == ERR_OK, first_slot_o <= last_slot_o, "range transfer with first above last")

endmodule

// ----- design/pbob_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbob_front
// Position to linear block index pipeline; flags out-of-range blocks.
// ----------------------------------------------------------------------------
module pbob_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbob_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pbob_pkg::POS_W-1:0]  pos_x_i,
  input  logic [pbob_pkg::POS_W-1:0]  pos_y_i,
  input  logic [pbob_pkg::POS_W-1:0]  pos_z_i,
  input  logic                        is_end_i,
  input  logic                        fifo_full_i,
  output logic                        push_o,
  output pbob_pkg::item_t             item_o
);
  import pbob_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_W - 1);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic e1_q, e2_q, e3_q, e4_q, e5_q, e6_q;

  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [PROD_W-1:0] px_d, py_d, pz_d;
  logic signed [PROD_W-1:0] sx, sy, sz;
  logic signed [CELL_W-1:0] cx_q, cy_q, cz_q;
  logic signed [CELL_W-1:0] bx3_q, by3_q, bz3_q;
  logic signed [CELL_W-1:0] lim_x, lim_y, lim_z;
  logic                     bad4_d, bad4_q, bad5_q, bad6_q;
  logic [ZY_W-1:0]          zy_q;
  logic [ZYB_W-1:0]         zyb_q;
  logic [LIN_W-1:0]         zybx_q;
  logic [LIN_W-1:0]         lin;
  logic [SLOT_W-1:0]        bx4_q, by4_q, bx5_q, bx6_q;

  assign adv        = !(v6_q && fifo_full_i);
  assign in_stall_o = !adv;

  assign px_d = PROD_W'($signed(pos_x_i)) * PROD_W'($signed({1'b0, cfg_i.inv_x}));
  assign py_d = PROD_W'($signed(pos_y_i)) * PROD_W'($signed({1'b0, cfg_i.inv_y}));
  assign pz_d = PROD_W'($signed(pos_z_i)) * PROD_W'($signed({1'b0, cfg_i.inv_z}));

  assign sx = px_q + HALF;
  assign sy = py_q + HALF;
  assign sz = pz_q + HALF;

  assign lim_x = $signed({{(CELL_W-SLOT_W){1'b0}}, cfg_i.blocks_x});
  assign lim_y = $signed({{(CELL_W-SLOT_W){1'b0}}, cfg_i.blocks_y});
  assign lim_z = $signed({{(CELL_W-SLOT_W){1'b0}}, cfg_i.blocks_z});

  assign bad4_d = (bx3_q < 0) || (bx3_q >= lim_x) ||
                  (by3_q < 0) || (by3_q >= lim_y) ||
                  (bz3_q < 0) || (bz3_q >= lim_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q   <= is_end_i;
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;

      e2_q   <= e1_q;
      cx_q   <= sx[PROD_W-1:FRAC_W];
      cy_q   <= sy[PROD_W-1:FRAC_W];
      cz_q   <= sz[PROD_W-1:FRAC_W];

      e3_q   <= e2_q;
      bx3_q  <= cx_q / CELL_W'(BLOCK_X);
      by3_q  <= cy_q / CELL_W'(BLOCK_Y);
      bz3_q  <= cz_q / CELL_W'(BLOCK_Z);

      e4_q   <= e3_q;
      bad4_q <= bad4_d;
      zy_q   <= ZY_W'(bz3_q[SLOT_W-1:0]) * ZY_W'(cfg_i.blocks_y);
      bx4_q  <= bx3_q[SLOT_W-1:0];
      by4_q  <= by3_q[SLOT_W-1:0];

      e5_q   <= e4_q;
      bad5_q <= bad4_q;
      zyb_q  <= ZYB_W'(zy_q) + ZYB_W'(by4_q);
      bx5_q  <= bx4_q;

      e6_q   <= e5_q;
      bad6_q <= bad5_q;
      zybx_q <= LIN_W'(zyb_q) * LIN_W'(cfg_i.blocks_x);
      bx6_q  <= bx5_q;
    end
  end

  assign lin    = zybx_q + LIN_W'(bx6_q);
  assign push_o = v6_q && adv;

  always_comb begin
    item_o.is_end = e6_q;
    if (e6_q) begin
      item_o.bad   = 1'b0;
      item_o.block = cfg_i.count;
    end else begin
      item_o.bad   = bad6_q || (lin >= LIN_W'(cfg_i.count));
      item_o.block = lin[SLOT_W-1:0];
    end
  end

endmodule

// ----- design/pbob_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbob_fifo
// Four-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module pbob_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pbob_pkg::item_t        item_i,
  input  logic                   pop_i,
  output pbob_pkg::item_t        item_o,
  output pbob_pkg::fifo_status_t status_o
);
  import pbob_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   fill_q;
  logic             do_push, do_pop;

  assign status_o.full  = (fill_q == (PTR_W+1)'(DEPTH));
  assign status_o.empty = (fill_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + PTR_W'(1);
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

// ----- design/pbob_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbob_back
// Block order tracking, range results and the output register.
// ----------------------------------------------------------------------------
module pbob_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pbob_pkg::item_t              item_i,
  input  logic                         item_valid_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pbob_pkg::SLOT_W-1:0]  first_slot_o,
  output logic [pbob_pkg::SLOT_W-1:0]  last_slot_o,
  output logic [pbob_pkg::IDX_W-1:0]   start_index_o,
  output logic [1:0]                   error_code_o
);
  import pbob_pkg::*;

  logic signed [PREV_W-1:0] prev_q, prev_d, prev_inc;
  logic [IDX_W-1:0]         pidx_q, pidx_d, pidx_inc;
  logic signed [PREV_W-1:0] blk;
  logic                     res_vld;
  logic [SLOT_W-1:0]        first_d, last_d;
  logic [IDX_W-1:0]         start_d;
  err_e                     err_d;
  logic                     out_valid_q;
  logic [SLOT_W-1:0]        first_q, last_q;
  logic [IDX_W-1:0]         start_q;
  err_e                     err_q;

  assign blk      = $signed({1'b0, item_i.block});
  assign prev_inc = prev_q + PREV_W'(1);
  assign pidx_inc = (pidx_q < IDX_W'(MAX_PARTICLES)) ? pidx_q + IDX_W'(1) : pidx_q;
  assign pop_o    = item_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    res_vld = 1'b0;
    first_d = '0;
    last_d  = '0;
    start_d = '0;
    err_d   = ERR_OK;
    prev_d  = prev_q;
    pidx_d  = pidx_q;
    if (pop_o) begin
      if (!item_i.is_end && item_i.bad) begin
        res_vld = 1'b1;
        err_d   = ERR_RANGE;
        pidx_d  = pidx_inc;
      end else begin
        if (blk > prev_q) begin
          res_vld = 1'b1;
          first_d = prev_inc[SLOT_W-1:0];
          last_d  = item_i.block;
          start_d = pidx_q;
          if (!item_i.is_end) prev_d = blk;
        end else if (blk < prev_q) begin
          res_vld = 1'b1;
          err_d   = ERR_ORDER;
        end
        if (item_i.is_end) begin
          prev_d = '1;
          pidx_d = '0;
        end else begin
          pidx_d = pidx_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '1;
      pidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      pidx_q <= pidx_d;
      if (pop_o) begin
        out_valid_q <= res_vld;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_vld) begin
      first_q <= first_d;
      last_q  <= last_d;
      start_q <= start_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign first_slot_o  = first_q;
  assign last_slot_o   = last_q;
  assign start_index_o = start_q;
  assign error_code_o  = err_q;

endmodule
